// File: rtl/bcvm_pkg.sv
// Shared types, codes and constants of the battery coulomb-counting voltage model.
package bcvm_pkg;

	// Item kinds carried in the kind field of an input transaction.
	localparam logic [1:0] KIND_ROTOR    = 2'd0;
	localparam logic [1:0] KIND_TICK     = 2'd1;
	localparam logic [1:0] KIND_RECHARGE = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 46;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_V     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_V     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 3'd4;

	// Register values after reset.
	localparam logic [15:0] FULL_V_RST     = 16'd16800;
	localparam logic [15:0] KNEE_V_RST     = 16'd13600;
	localparam logic [18:0] CUR_LIMIT_RST  = 19'd100000;
	localparam logic [45:0] CAPACITY_RST   = 46'd18000000000000;
	localparam logic [19:0] RESISTANCE_RST = 20'd20000;

	localparam logic [18:0] SUM_MAX   = 19'h7FFFF;
	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [46:0] NV_PER_MV = 47'd1000000;

	// Radix-2 divider step count for the state-of-charge quotient.
	localparam int SOC_STEPS = 16;

	// The drop in nV is divided by 1e6 as (drop / 64) / 15625. The quotient is first
	// estimated with a reciprocal of 2^32 / 15625, which is at most two low, and then
	// corrected from the remainder.
	localparam logic [15:0] DROP_DIV   = 16'd15625;
	localparam logic [15:0] DROP_DIV2  = 16'd31250;
	localparam logic [18:0] DROP_RECIP = 19'd274877;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  rotor_index;
		logic [15:0] rotor_current_ma;
		logic [15:0] dt_us;
	} in_item_t;

	typedef struct packed {
		logic [15:0] voltage_mv;
		logic [18:0] current_ma;
		logic        over_limit;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_USED,
		ST_CHARGE,
		ST_SOC_INIT,
		ST_SOC_DIV,
		ST_OCV_MUL,
		ST_VOLT,
		ST_DROP_REM,
		ST_OUT
	} state_t;

endpackage

// File: rtl/battery_coulomb_voltage_model.sv
// Battery model: rotor current table, coulomb counter and piecewise-linear voltage curve.
// A tick sweeps the table (one read a cycle), runs the 16-step state-of-charge divider
// (skipped when the charge is at or above capacity) and the curve and drop steps; rotor
// and recharge transactions are taken without leaving the idle state. No new tick is
// taken until the result of the last one is loaded, and a result not taken holds the block.
// Reset is asynchronous, active low: table reads zero, charge and registers reset values.
module battery_coulomb_voltage_model #(
	parameter int NUM_ROTORS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bcvm_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bcvm_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bcvm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bcvm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bcvm_pkg::*;

	// Table address width, sweep counter width (it must hold NUM_ROTORS itself) and the
	// width the 3-bit rotor index is extended to before it is cut down to an address.
	localparam int AW = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
	localparam int CW = $clog2(NUM_ROTORS + 1);
	localparam int XW = (AW > 3) ? AW : 3;
	localparam logic [CW-1:0] CNT_LAST = CW'(NUM_ROTORS);

	// Configuration registers.
	logic [15:0] full_v_q;
	logic [15:0] knee_v_q;
	logic [18:0] lim_q;
	logic [45:0] cap_q;
	logic [19:0] res_q;

	// Sequencer.
	state_t state_q, state_d;
	logic   in_acc;
	logic   out_load;

	// Rotor current table: a one-write, one-read memory with a valid bit per entry so that
	// an entry never written since reset reads as zero.
	logic [15:0]           mem [NUM_ROTORS];
	logic [NUM_ROTORS-1:0] vld_q;
	logic                  idx_ok;
	logic                  wr_en;
	logic [XW-1:0]         idx_x;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [CW-1:0]         cnt_q;
	logic [15:0]           rd_data_s1;
	logic                  rd_vld_s1;
	logic                  acc_s1;

	// Summed current and charge bookkeeping.
	logic [18:0] sum_q;
	logic [19:0] sum_add;
	logic [15:0] dt_q;
	logic [34:0] used_q;
	logic [38:0] drop_q;
	logic [45:0] charge_q;

	// Restoring divider for the state of charge.
	logic [46:0] r_q;
	logic [46:0] r_shift;
	logic [46:0] divisor;
	logic [15:0] quo_q;
	logic [4:0]  dcnt_q;
	logic        div_ge;
	logic        div_step;

	// Drop in mV by reciprocal estimate and remainder correction.
	logic [32:0] drop_x;
	logic [51:0] est_prod;
	logic [19:0] dq_q;
	logic [33:0] rem_full;
	logic [15:0] rem_q;
	logic [1:0]  drop_fix;
	logic        drop_exact;

	// Open-circuit voltage curve and terminal voltage.
	logic        soc_full_q;
	logic [16:0] soc;
	logic [18:0] s5;
	logic        below;
	logic [15:0] mul_a;
	logic [18:0] mul_b;
	logic [34:0] prod_q;
	logic        below_q;
	logic        rise_q;
	logic [15:0] v_d;
	logic [15:0] v_q;
	logic [20:0] drop_mv;
	logic [15:0] vout;

	// Result register.
	out_item_t out_q;
	logic      out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The user must write configuration only while idle; the block does not enforce it. A new
	// value takes effect for the next transaction. Capacity reaches the charge only on recharge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_v_q <= FULL_V_RST;
			knee_v_q <= KNEE_V_RST;
			lim_q    <= CUR_LIMIT_RST;
			cap_q    <= CAPACITY_RST;
			res_q    <= RESISTANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FULL_V:     full_v_q <= cfg_data[15:0];
				REG_KNEE_V:     knee_v_q <= cfg_data[15:0];
				REG_CUR_LIMIT:  lim_q    <= cfg_data[18:0];
				REG_CAPACITY:   cap_q    <= cfg_data[45:0];
				REG_RESISTANCE: res_q    <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Rotor updates. An index at or beyond NUM_ROTORS is dropped without a trace.
	assign idx_ok = (int'(in_data.rotor_index) < NUM_ROTORS);
	assign wr_en  = in_acc && (in_data.kind == KIND_ROTOR) && idx_ok;
	assign idx_x  = XW'(in_data.rotor_index);
	assign waddr  = idx_x[AW-1:0];
	assign raddr  = (cnt_q < CNT_LAST) ? cnt_q[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= in_data.rotor_current_ma;
		end
		rd_data_s1 <= mem[raddr];
		rd_vld_s1  <= vld_q[raddr];
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. A tick sweeps the table, takes the used charge off, divides for the state
	// of charge (unless at or above capacity), evaluates the curve, reduces the drop to mV and
	// loads the result register, waiting there only while an earlier result has not been taken.
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		div_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_data.kind == KIND_TICK)) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_USED;
				end
			end
			ST_USED:   state_d = ST_CHARGE;
			ST_CHARGE: state_d = ST_SOC_INIT;
			ST_SOC_INIT: begin
				// At or above capacity the fraction saturates at one, no division needed.
				state_d = (charge_q >= cap_q) ? ST_OCV_MUL : ST_SOC_DIV;
			end
			ST_SOC_DIV: begin
				div_step = 1'b1;
				if (dcnt_q == 5'(SOC_STEPS - 1)) begin
					state_d = ST_OCV_MUL;
				end
			end
			ST_OCV_MUL:  state_d = ST_VOLT;
			ST_VOLT:     state_d = ST_DROP_REM;
			ST_DROP_REM: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state: valid bits, sweep counter, remaining charge and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			cnt_q       <= '0;
			acc_s1      <= 1'b0;
			charge_q    <= CAPACITY_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[waddr] <= 1'b1;
			end
			acc_s1 <= (state_q == ST_SUM) && (cnt_q < CNT_LAST);
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if ((state_q == ST_SUM) && (cnt_q < CNT_LAST)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (in_acc && (in_data.kind == KIND_RECHARGE)) begin
				charge_q <= cap_q;
			end else if (state_q == ST_CHARGE) begin
				// Coulomb counting with a floor at empty.
				charge_q <= (charge_q > 46'(used_q)) ? (charge_q - 46'(used_q)) : '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Table sum, saturating. The read data is registered and arrives in the cycle after its address.
	assign sum_add = 20'(sum_q) + 20'(rd_vld_s1 ? rd_data_s1 : 16'd0);

	// Divider step: shift a zero into the partial remainder (the dividend is the charge
	// times 2^16) and subtract the capacity where it fits. The partial remainder always
	// stays below the capacity.
	assign divisor = {1'b0, cap_q};
	assign r_shift = {r_q[45:0], 1'b0};
	assign div_ge  = (r_shift >= divisor);

	// State of charge in Q16 and the curve operands. Below the knee (five times the
	// fraction under one) the voltage rises from zero to the knee voltage; above it the
	// difference between full and knee voltage is scaled by the distance past the knee.
	assign soc   = soc_full_q ? ONE_Q16 : {1'b0, quo_q};
	assign s5    = {soc, 2'b00} + 19'(soc);
	assign below = (s5[18:16] == 3'd0);
	assign mul_a = below ? knee_v_q
		: ((full_v_q >= knee_v_q) ? (full_v_q - knee_v_q) : (knee_v_q - full_v_q));
	assign mul_b = below ? s5 : (s5 - 19'(ONE_Q16));

	// The slope term is truncated toward zero on both the rising and falling segment.
	assign v_d = below_q ? prod_q[31:16]
		: (rise_q ? (knee_v_q + prod_q[33:18]) : (knee_v_q - prod_q[33:18]));

	// Drop in mV. The low six bits of the drop only matter for the rounding; the rest is
	// divided by 15625. The estimate is at most two low, so the remainder is below three
	// divisors and two compares finish the quotient.
	assign drop_x     = drop_q[38:6];
	assign est_prod   = 52'(drop_x) * 52'(DROP_RECIP);
	assign rem_full   = 34'(drop_x) - 34'(dq_q) * 34'(DROP_DIV);
	assign drop_fix   = (rem_q >= DROP_DIV2) ? 2'd2 : ((rem_q >= DROP_DIV) ? 2'd1 : 2'd0);
	assign drop_exact = (rem_q inside {16'd0, DROP_DIV, DROP_DIV2}) && (drop_q[5:0] == 6'd0);

	// Terminal voltage: floor((v * 1e6 - drop_nv) / 1e6) equals v - ceil(drop_nv / 1e6),
	// floored at zero.
	assign drop_mv = 21'(dq_q) + 21'(drop_fix) + 21'(!drop_exact);
	assign vout    = ({5'd0, v_q} > drop_mv) ? 16'({5'd0, v_q} - drop_mv) : 16'd0;

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc && (in_data.kind == KIND_TICK)) begin
			dt_q  <= in_data.dt_us;
			sum_q <= '0;
		end else if ((state_q == ST_SUM) && acc_s1) begin
			sum_q <= sum_add[19] ? SUM_MAX : sum_add[18:0];
		end

		if (state_q == ST_USED) begin
			used_q <= 35'(sum_q) * 35'(dt_q);
			drop_q <= 39'(res_q) * 39'(sum_q);
		end

		if (state_q == ST_SOC_INIT) begin
			soc_full_q <= (charge_q >= cap_q);
			r_q        <= {1'b0, charge_q};
			quo_q      <= '0;
			dcnt_q     <= '0;
		end else if (div_step) begin
			r_q    <= div_ge ? (r_shift - divisor) : r_shift;
			quo_q  <= {quo_q[14:0], div_ge};
			dcnt_q <= dcnt_q + 1'b1;
		end

		if (state_q == ST_OCV_MUL) begin
			prod_q  <= 35'(mul_a) * 35'(mul_b);
			below_q <= below;
			rise_q  <= (full_v_q >= knee_v_q);
		end

		if (state_q == ST_VOLT) begin
			v_q  <= v_d;
			dq_q <= est_prod[51:32];
		end

		if (state_q == ST_DROP_REM) begin
			rem_q <= rem_full[15:0];
		end

		if (out_load) begin
			out_q.voltage_mv <= vout;
			out_q.current_ma <= sum_q;
			out_q.over_limit <= (sum_q > lim_q);
		end
	end

endmodule

// File: rtl/bcvm_checker.sv
// Port-level checks of the battery model, bound to its top level.
module bcvm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input bcvm_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input bcvm_pkg::out_item_t out_data
);
	import bcvm_pkg::*;

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// An accepted tick keeps the block busy on the next cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.kind == KIND_TICK) |=> !in_ready)
		else $error("block ready right after accepting a tick");

	// Rotor updates, recharges and unused kinds leave the block ready on the next cycle.
	a_other_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.kind != KIND_TICK) |=> in_ready)
		else $error("block not ready after a transaction that gives no result");

	// A new result only appears out of tick processing.
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind battery_coulomb_voltage_model bcvm_checker u_bcvm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
